// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/btsch_pkg.sv -----
// ---------------------------------------------------------------------------
// Button trigger scheduler package
// Sizes, codes, shared types and the button group lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package btsch_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int NUM_BUTTONS = 8;
    localparam int NUM_GROUPS  = 8;

    localparam int SLOT_W   = 3;
    localparam int BTN_W    = 3;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Trigger modes held two bits per slot.
    localparam logic [1:0] MODE_PRESSED  = 2'd0;
    localparam logic [1:0] MODE_HELD     = 2'd1;
    localparam logic [1:0] MODE_RELEASED = 2'd2;
    localparam logic [1:0] MODE_TOGGLED  = 2'd3;

    // Action codes on the result.
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS     = 2'd2;

    typedef struct packed {
        logic [15:0] slot_modes;
        logic [23:0] slot_button_map;
        logic [31:0] button_groups;
    } btsch_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] id;
    } btsch_grp_t;

    // Group membership of button b; buttons without a nibble are in no group.
    function automatic btsch_grp_t grp_of(input logic [31:0] groups, input int b);
        logic [31:0] sh;
        btsch_grp_t  g;
        sh      = groups >> (4 * b);
        g.id    = sh[2:0];
        g.valid = sh[3] && (int'(sh[2:0]) < NUM_GROUPS) && (b < 8);
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/btsch_cfg.sv -----
// ---------------------------------------------------------------------------
// Configuration registers
// Holds slot modes, slot to button map and button groups.
// ---------------------------------------------------------------------------
`default_nettype none

module btsch_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [btsch_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [btsch_pkg::CFG_DATA_W-1:0] cfg_data,
    output btsch_pkg::btsch_cfg_t                cfg
);
    import btsch_pkg::*;

    btsch_cfg_t cfg_reg;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLOT_MODES: cfg_reg.slot_modes      <= cfg_data[15:0];
                CFG_SLOT_MAP:   cfg_reg.slot_button_map <= cfg_data[23:0];
                CFG_GROUPS:     cfg_reg.button_groups   <= cfg_data;
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/btsch_step.sv -----
// ---------------------------------------------------------------------------
// Trigger evaluation
// Edge detection, mode decode, toggle bits with group clear, and the
// per-slot last level and per-button toggle state.
// ---------------------------------------------------------------------------
`default_nettype none

module btsch_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire logic [btsch_pkg::SLOT_W-1:0]      slot,
    input  wire logic                              level,
    input  btsch_pkg::btsch_cfg_t                  cfg,
    output logic      [btsch_pkg::ACTION_W-1:0]    action,
    output logic                                   toggle_on
);
    import btsch_pkg::*;

    logic [NUM_SLOTS-1:0]   last_reg;
    logic [NUM_SLOTS-1:0]   last_next;
    logic [NUM_BUTTONS-1:0] tog_reg;
    logic [NUM_BUTTONS-1:0] tog_next;

    logic [NUM_SLOTS-1:0]   slot_sel;
    logic [NUM_BUTTONS-1:0] btn_sel;
    logic [15:0]            mode_sh;
    logic [23:0]            map_sh;
    logic [1:0]             mode;
    logic [BTN_W-1:0]       btn;
    logic                   ok;
    logic                   prev;
    logic                   cur_tog;
    logic                   new_tog;
    logic                   rise;
    btsch_grp_t             my_grp;
    btsch_grp_t             oth_grp;
    logic [ACTION_W-1:0]    act;

    // Decode the slot's mode and button, then evaluate one step.
    always_comb
    begin
        mode_sh = cfg.slot_modes >> (2 * int'(slot));
        map_sh  = cfg.slot_button_map >> (3 * int'(slot));
        mode    = mode_sh[1:0];
        btn     = map_sh[BTN_W-1:0];
        ok      = (int'(slot) < NUM_SLOTS) && (int'(btn) < NUM_BUTTONS);

        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_sel[s] = (int'(slot) == s);
        end
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            btn_sel[b] = (int'(btn) == b);
        end

        prev    = |(last_reg & slot_sel);
        cur_tog = |(tog_reg & btn_sel);
        rise    = level && !prev;
        my_grp  = grp_of(cfg.button_groups, int'(btn));
        oth_grp = '0;

        tog_next = tog_reg;
        act      = ACT_NONE;

        unique case (mode)
            MODE_PRESSED:
            begin
                if (rise)
                begin
                    act = ACT_START;
                end
            end
            MODE_HELD:
            begin
                if (level)
                begin
                    act = ACT_START;
                end
                else if (prev)
                begin
                    act = ACT_CANCEL;
                end
            end
            MODE_RELEASED:
            begin
                if (!level && prev)
                begin
                    act = ACT_START;
                end
            end
            MODE_TOGGLED:
            begin
                if (rise)
                begin
                    tog_next = tog_reg ^ btn_sel;
                    // Turning on clears the other members of the button's group.
                    if (!cur_tog && my_grp.valid)
                    begin
                        for (int b = 0; b < NUM_BUTTONS; b++)
                        begin
                            oth_grp = grp_of(cfg.button_groups, b);
                            if (!btn_sel[b] && oth_grp.valid && (oth_grp.id == my_grp.id))
                            begin
                                tog_next[b] = 1'b0;
                            end
                        end
                    end
                end
                if (|(tog_next & btn_sel))
                begin
                    act = ACT_START;
                end
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase

        // Out-of-range slot or button leaves all state alone.
        if (!ok)
        begin
            tog_next = tog_reg;
            act      = ACT_NONE;
        end
        new_tog = ok && |(tog_next & btn_sel);

        if (ok)
        begin
            last_next = (last_reg & ~slot_sel) | (slot_sel & {NUM_SLOTS{level}});
        end
        else
        begin
            last_next = last_reg;
        end
    end

    assign action    = act;
    assign toggle_on = new_tog;

    // State advances only when the evaluated item moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            tog_reg  <= '0;
        end
        else if (fire)
        begin
            last_reg <= last_next;
            tog_reg  <= tog_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/button_trigger_scheduler_core.sv -----
// Flow: an accepted request waits in the input register until the result
// register is free, then moves to the result register, held there until taken.
// Throughput: one request per cycle unless the output stalls; the trigger logic sits
// between the input register and the result register, and state updates as each request leaves.
// Reset: rst_n asynchronously clears configuration, last levels (released),
// toggle bits (off) and both valid flags; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Button trigger scheduler core
// Input register, trigger evaluation, result register and configuration port.
// ---------------------------------------------------------------------------
`default_nettype none

module button_trigger_scheduler_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [btsch_pkg::SLOT_W-1:0]      slot_index,
    input  wire logic                              button_level,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [btsch_pkg::SLOT_W-1:0]      slot_echo,
    output logic      [btsch_pkg::ACTION_W-1:0]    action,
    output logic                                   toggle_on,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [btsch_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [btsch_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import btsch_pkg::*;

    btsch_cfg_t          cfg;
    logic                in_vld_reg;
    logic [SLOT_W-1:0]   in_slot_reg;
    logic                in_level_reg;
    logic                out_vld_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [ACTION_W-1:0] out_act_reg;
    logic                out_tog_reg;
    logic                out_free;
    logic                fire;
    logic                in_take;
    logic [ACTION_W-1:0] step_act;
    logic                step_tog;

    // Configuration is always writable.
    assign cfg_ready = 1'b1;

    btsch_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline flow control.
    assign out_free = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_slot_reg  <= slot_index;
            in_level_reg <= button_level;
        end
    end

    btsch_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .slot      (in_slot_reg),
        .level     (in_level_reg),
        .cfg       (cfg),
        .action    (step_act),
        .toggle_on (step_tog)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_slot_reg <= in_slot_reg;
            out_act_reg  <= step_act;
            out_tog_reg  <= step_tog;
        end
    end

    assign out_valid = out_vld_reg;
    assign slot_echo = out_slot_reg;
    assign action    = out_act_reg;
    assign toggle_on = out_tog_reg;

    // Checks on the pipeline control.
    `include "assert_macros.svh"

    `ASSERT_IMP(a_stall_has_item, clk, rst_n, in_stall, in_vld_reg, "stall without held request")
    `ASSERT_NXT(a_fire_gives_result, clk, rst_n, fire, out_vld_reg, "evaluated request lost")
    `ASSERT_NXT(a_held_item_kept, clk, rst_n, in_vld_reg && !fire, in_vld_reg, "held request dropped")

endmodule

`default_nettype wire
